// ===== rtl/kdqd_pkg.sv =====
package kdqd_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned AB_W     = 2;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned DELTA_W  = 2;
    localparam int unsigned CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD     = 8'd1;

    localparam logic [PERIOD_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [PERIOD_W-1:0] SCAN_RESET     = 16'd5;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [POS_W-1:0]   position_t;

    // Quadrature step, indexed by {previous A/B, current A/B}.
    localparam delta_t STEP_TABLE [16] = '{
        2'sb00, 2'sb11, 2'sb01, 2'sb00,
        2'sb01, 2'sb00, 2'sb00, 2'sb11,
        2'sb11, 2'sb00, 2'sb00, 2'sb01,
        2'sb00, 2'sb01, 2'sb11, 2'sb00
    };

endpackage

// ===== rtl/kdqd_in_if.sv =====
interface kdqd_in_if #(
    parameter int unsigned KEY_W = 6
);
    logic                           valid;
    logic                           ready;
    logic [kdqd_pkg::TIME_W-1:0]    now_ms;
    logic [KEY_W-1:0]               key_raw;
    logic [kdqd_pkg::AB_W-1:0]      enc0_ab;
    logic [kdqd_pkg::AB_W-1:0]      enc1_ab;

    modport source (output valid, output now_ms, output key_raw, output enc0_ab,
                    output enc1_ab, input ready);
    modport sink (input valid, input now_ms, input key_raw, input enc0_ab,
                  input enc1_ab, output ready);
endinterface

// ===== rtl/kdqd_out_if.sv =====
interface kdqd_out_if #(
    parameter int unsigned KEY_W = 6
);
    logic                   valid;
    logic                   ready;
    logic [KEY_W-1:0]       pressed;
    logic [KEY_W-1:0]       just_pressed;
    logic [KEY_W-1:0]       just_released;
    kdqd_pkg::position_t    enc0_position;
    kdqd_pkg::delta_t       enc0_delta;
    kdqd_pkg::position_t    enc1_position;
    kdqd_pkg::delta_t       enc1_delta;

    modport source (output valid, output pressed, output just_pressed,
                    output just_released, output enc0_position, output enc0_delta,
                    output enc1_position, output enc1_delta, input ready);
    modport sink (input valid, input pressed, input just_pressed,
                  input just_released, input enc0_position, input enc0_delta,
                  input enc1_position, input enc1_delta, output ready);
endinterface

// ===== rtl/kdqd_cfg_if.sv =====
interface kdqd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [kdqd_pkg::CFG_IDX_W-1:0]     index;
    logic [kdqd_pkg::PERIOD_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/kdqd_keys.sv =====
module kdqd_keys #(
    parameter int unsigned NKEYS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic [kdqd_pkg::TIME_W-1:0]         now_ms,
    input  logic [NKEYS-1:0]                    key_raw,
    input  logic [kdqd_pkg::PERIOD_W-1:0]       debounce_period,
    input  logic [kdqd_pkg::PERIOD_W-1:0]       scan_period,
    output logic [NKEYS-1:0]                    pressed,
    output logic [NKEYS-1:0]                    just_pressed,
    output logic [NKEYS-1:0]                    just_released
);

    logic [kdqd_pkg::TIME_W-1:0] last_scan_reg;
    logic [kdqd_pkg::TIME_W-1:0] last_scan_next;
    logic [NKEYS-1:0]            raw_reg;
    logic [NKEYS-1:0]            raw_next;
    logic [NKEYS-1:0]            confirmed_reg;
    logic [NKEYS-1:0]            confirmed_next;
    logic [kdqd_pkg::TIME_W-1:0] since_reg  [NKEYS];
    logic [kdqd_pkg::TIME_W-1:0] since_next [NKEYS];
    logic [kdqd_pkg::TIME_W-1:0] scan_gap;
    logic                        scan_due;
    logic [kdqd_pkg::TIME_W-1:0] held [NKEYS];
    logic [NKEYS-1:0]            changed;
    logic [NKEYS-1:0]            confirm;

    assign scan_gap = now_ms - last_scan_reg;
    assign scan_due = scan_gap >= {{(kdqd_pkg::TIME_W-kdqd_pkg::PERIOD_W){1'b0}}, scan_period};

    always_comb
    begin
        last_scan_next = scan_due ? now_ms : last_scan_reg;
        for (int k = 0; k < NKEYS; k++)
        begin
            changed[k] = key_raw[k] != raw_reg[k];
            // A fresh change restarts the timer at this update, so it has held for zero.
            held[k] = changed[k] ? '0 : now_ms - since_reg[k];
            confirm[k] = scan_due &&
                (held[k] >= {{(kdqd_pkg::TIME_W-kdqd_pkg::PERIOD_W){1'b0}}, debounce_period});
            raw_next[k] = scan_due ? key_raw[k] : raw_reg[k];
            since_next[k] = (scan_due && changed[k]) ? now_ms : since_reg[k];
            confirmed_next[k] = confirm[k] ? key_raw[k] : confirmed_reg[k];
            just_pressed[k] = confirm[k] && key_raw[k] && !confirmed_reg[k];
            just_released[k] = confirm[k] && !key_raw[k] && confirmed_reg[k];
        end
    end

    assign pressed = confirmed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_scan_reg <= '0;
            raw_reg <= '0;
            confirmed_reg <= '0;
            for (int k = 0; k < NKEYS; k++)
            begin
                since_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            last_scan_reg <= last_scan_next;
            raw_reg <= raw_next;
            confirmed_reg <= confirmed_next;
            for (int k = 0; k < NKEYS; k++)
            begin
                since_reg[k] <= since_next[k];
            end
        end
    end

endmodule

// ===== rtl/kdqd_enc.sv =====
module kdqd_enc (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            primed,
    input  logic [kdqd_pkg::AB_W-1:0]       ab,
    output kdqd_pkg::position_t             position,
    output kdqd_pkg::delta_t                delta
);

    logic [kdqd_pkg::AB_W-1:0]  prev_ab_reg;
    kdqd_pkg::position_t        position_reg;
    kdqd_pkg::position_t        position_next;

    // An illegal transition reads as zero from the table; the new pins are kept anyway.
    assign delta = primed ? kdqd_pkg::STEP_TABLE[{prev_ab_reg, ab}] : '0;
    assign position_next = position_reg +
        {{(kdqd_pkg::POS_W-kdqd_pkg::DELTA_W){delta[kdqd_pkg::DELTA_W-1]}}, delta};
    assign position = position_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg <= '0;
            position_reg <= '0;
        end
        else if (advance)
        begin
            prev_ab_reg <= ab;
            position_reg <= position_next;
        end
    end

endmodule

// ===== rtl/key_debounce_and_quadrature_decode.sv =====
// Channel   Role    Payload
// update    sink    now_ms, key_raw, enc0_ab, enc1_ab
// result    source  pressed, just_pressed, just_released, encN_position, encN_delta
// cfg       sink    index, data (0: debounce_period, 1: scan_period)
//
// Each update is taken into an input register and its result is registered in the
// result register as it advances, updating key and encoder state, so one update is
// taken every cycle while not stalled. The input register refills while a result is
// held, so a stalled result costs no throughput until both stages are full. Reset
// clears valid flags and key/encoder state, sets default periods; config is always
// ready. The user must have config written only when the block is idle (unenforced).
module key_debounce_and_quadrature_decode #(
    parameter int unsigned ROWS = 3,
    parameter int unsigned COLS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    kdqd_in_if.sink     update,
    kdqd_out_if.source  result,
    kdqd_cfg_if.sink    cfg
);

    localparam int unsigned NKEYS = ROWS * COLS;

    logic [kdqd_pkg::PERIOD_W-1:0]  debounce_reg;
    logic [kdqd_pkg::PERIOD_W-1:0]  scan_reg;

    logic                           in_valid_reg;
    logic [kdqd_pkg::TIME_W-1:0]    now_reg;
    logic [NKEYS-1:0]               keys_reg;
    logic [kdqd_pkg::AB_W-1:0]      ab0_reg;
    logic [kdqd_pkg::AB_W-1:0]      ab1_reg;
    logic                           primed_reg;

    logic                           out_valid_reg;
    logic [NKEYS-1:0]               pressed_reg;
    logic [NKEYS-1:0]               jp_reg;
    logic [NKEYS-1:0]               jr_reg;
    kdqd_pkg::position_t            pos0_reg;
    kdqd_pkg::delta_t               delta0_reg;
    kdqd_pkg::position_t            pos1_reg;
    kdqd_pkg::delta_t               delta1_reg;

    logic                           advance;
    logic                           take;
    logic [NKEYS-1:0]               pressed_next;
    logic [NKEYS-1:0]               jp_next;
    logic [NKEYS-1:0]               jr_next;
    kdqd_pkg::position_t            pos0_next;
    kdqd_pkg::delta_t               delta0_next;
    kdqd_pkg::position_t            pos1_next;
    kdqd_pkg::delta_t               delta1_next;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign update.ready = !in_valid_reg || advance;
    assign take = update.valid && update.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kdqd_pkg::DEBOUNCE_RESET;
            scan_reg <= kdqd_pkg::SCAN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                kdqd_pkg::REG_DEBOUNCE_PERIOD:
                begin
                    debounce_reg <= cfg.data;
                end
                kdqd_pkg::REG_SCAN_PERIOD:
                begin
                    scan_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            primed_reg <= 1'b0;
        end
        else
        begin
            if (take || advance)
            begin
                in_valid_reg <= take;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                primed_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            now_reg <= update.now_ms;
            keys_reg <= update.key_raw;
            ab0_reg <= update.enc0_ab;
            ab1_reg <= update.enc1_ab;
        end
        if (advance)
        begin
            pressed_reg <= pressed_next;
            jp_reg <= jp_next;
            jr_reg <= jr_next;
            pos0_reg <= pos0_next;
            delta0_reg <= delta0_next;
            pos1_reg <= pos1_next;
            delta1_reg <= delta1_next;
        end
    end

    kdqd_keys #(
        .NKEYS(NKEYS)
    ) u_keys (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .now_ms         (now_reg),
        .key_raw        (keys_reg),
        .debounce_period(debounce_reg),
        .scan_period    (scan_reg),
        .pressed        (pressed_next),
        .just_pressed   (jp_next),
        .just_released  (jr_next)
    );

    kdqd_enc u_enc0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .primed  (primed_reg),
        .ab      (ab0_reg),
        .position(pos0_next),
        .delta   (delta0_next)
    );

    kdqd_enc u_enc1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .primed  (primed_reg),
        .ab      (ab1_reg),
        .position(pos1_next),
        .delta   (delta1_next)
    );

    assign result.valid = out_valid_reg;
    assign result.pressed = pressed_reg;
    assign result.just_pressed = jp_reg;
    assign result.just_released = jr_reg;
    assign result.enc0_position = pos0_reg;
    assign result.enc0_delta = delta0_reg;
    assign result.enc1_position = pos1_reg;
    assign result.enc1_delta = delta1_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned ROWS = 3;
    localparam int unsigned COLS = 2;
    localparam int unsigned KEY_W = ROWS * COLS;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned SEGMENT_ITEMS = 210;
    localparam logic [kdqd_pkg::CFG_IDX_W-1:0] REG_BEYOND_LIST = 8'hFF;

    typedef struct {
        logic [KEY_W-1:0]    pressed;
        logic [KEY_W-1:0]    just_pressed;
        logic [KEY_W-1:0]    just_released;
        kdqd_pkg::position_t enc0_position;
        kdqd_pkg::delta_t    enc0_delta;
        kdqd_pkg::position_t enc1_position;
        kdqd_pkg::delta_t    enc1_delta;
    } key_enc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kdqd_in_if  #(.KEY_W(KEY_W)) upd_if ();
    kdqd_out_if #(.KEY_W(KEY_W)) res_if ();
    kdqd_cfg_if                  cfg_bus ();

    key_debounce_and_quadrature_decode #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .update(upd_if),
        .result(res_if),
        .cfg(cfg_bus)
    );

    always #2 clk = ~clk;

    // Predicted state of the block, kept in step with accepted transactions.
    logic [kdqd_pkg::PERIOD_W-1:0] debounce_len = kdqd_pkg::DEBOUNCE_RESET;
    logic [kdqd_pkg::PERIOD_W-1:0] scan_ms = kdqd_pkg::SCAN_RESET;
    logic [kdqd_pkg::TIME_W-1:0]   last_scan_ms = '0;
    logic [KEY_W-1:0]              raw_keys = '0;
    logic [kdqd_pkg::TIME_W-1:0]   stable_since [KEY_W] = '{default: '0};
    logic [KEY_W-1:0]              held_keys = '0;
    logic [kdqd_pkg::AB_W-1:0]     prev_ab [2] = '{default: '0};
    kdqd_pkg::position_t           enc_position [2] = '{default: '0};
    logic                          primed = 1'b0;

    key_enc_result_t pending_results [$];
    int unsigned     fault_count = 0;
    int unsigned     quiet_cycles = 0;
    int unsigned     hold_off_left = 0;
    logic            gaps_enabled = 1'b1;

    logic [kdqd_pkg::TIME_W-1:0] stim_ms = 32'd300000;
    logic [kdqd_pkg::AB_W-1:0]   enc0_pins = '0;
    logic [kdqd_pkg::AB_W-1:0]   enc1_pins = '0;

    function automatic key_enc_result_t decode_update(
        input logic [kdqd_pkg::TIME_W-1:0] now,
        input logic [KEY_W-1:0] keys,
        input logic [kdqd_pkg::AB_W-1:0] ab0,
        input logic [kdqd_pkg::AB_W-1:0] ab1);
        key_enc_result_t r;
        logic [kdqd_pkg::AB_W-1:0] pins [2];
        logic [1:0] g_prev;
        logic [1:0] g_cur;
        logic [1:0] turn;
        kdqd_pkg::delta_t step [2];
        r.just_pressed = '0;
        r.just_released = '0;
        step[0] = '0;
        step[1] = '0;
        pins[0] = ab0;
        pins[1] = ab1;
        if (32'(now - last_scan_ms) >= 32'(scan_ms))
        begin
            last_scan_ms = now;
            for (int k = 0; k < KEY_W; k++)
            begin
                if (keys[k] != raw_keys[k])
                begin
                    raw_keys[k] = keys[k];
                    stable_since[k] = now;
                end
                if (32'(now - stable_since[k]) >= 32'(debounce_len))
                begin
                    if (!held_keys[k] && keys[k])
                        r.just_pressed[k] = 1'b1;
                    if (held_keys[k] && !keys[k])
                        r.just_released[k] = 1'b1;
                    held_keys[k] = keys[k];
                end
            end
        end
        // Pins are mapped to their place on the Gray cycle 00, 01, 11, 10; moving
        // one place along that cycle counts down, one place back counts up.
        for (int e = 0; e < 2; e++)
        begin
            if (primed)
            begin
                g_prev = {prev_ab[e][1], prev_ab[e][1] ^ prev_ab[e][0]};
                g_cur = {pins[e][1], pins[e][1] ^ pins[e][0]};
                turn = g_cur - g_prev;
                if (turn == 2'd1)
                    step[e] = -2'sd1;
                else if (turn == 2'd3)
                    step[e] = 2'sd1;
                enc_position[e] = enc_position[e] + step[e];
            end
            prev_ab[e] = pins[e];
        end
        primed = 1'b1;
        r.pressed = held_keys;
        r.enc0_position = enc_position[0];
        r.enc0_delta = step[0];
        r.enc1_position = enc_position[1];
        r.enc1_delta = step[1];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        key_enc_result_t want;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                if (cfg_bus.index == kdqd_pkg::REG_DEBOUNCE_PERIOD)
                    debounce_len = cfg_bus.data;
                else if (cfg_bus.index == kdqd_pkg::REG_SCAN_PERIOD)
                    scan_ms = cfg_bus.data;
            end
            if (upd_if.valid && upd_if.ready)
                pending_results.push_back(decode_update(upd_if.now_ms, upd_if.key_raw,
                                                        upd_if.enc0_ab, upd_if.enc1_ab));
            if (res_if.valid && res_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction arrived with nothing expected");
                    fault_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("pressed", want.pressed, res_if.pressed);
                    check_field("just_pressed", want.just_pressed, res_if.just_pressed);
                    check_field("just_released", want.just_released, res_if.just_released);
                    check_field("enc0_position", want.enc0_position, res_if.enc0_position);
                    check_field("enc0_delta", want.enc0_delta, res_if.enc0_delta);
                    check_field("enc1_position", want.enc1_position, res_if.enc1_position);
                    check_field("enc1_delta", want.enc1_delta, res_if.enc1_delta);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((upd_if.valid && upd_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiving side: random stalls, always ready with gaps off, or a long hold-off while one is requested.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            res_if.ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else if (gaps_enabled)
            res_if.ready <= ($urandom_range(99) >= 32);
        else
            res_if.ready <= 1'b1;
    end

    task automatic send_update(input logic [kdqd_pkg::TIME_W-1:0] now,
                               input logic [KEY_W-1:0] keys,
                               input logic [kdqd_pkg::AB_W-1:0] ab0,
                               input logic [kdqd_pkg::AB_W-1:0] ab1);
        @(negedge clk);
        while (gaps_enabled && $urandom_range(99) < 32)
        begin
            upd_if.valid <= 1'b0;
            @(negedge clk);
        end
        upd_if.valid <= 1'b1;
        upd_if.now_ms <= now;
        upd_if.key_raw <= keys;
        upd_if.enc0_ab <= ab0;
        upd_if.enc1_ab <= ab1;
        do
            @(posedge clk);
        while (!upd_if.ready);
    endtask

    // Lowers valid, then lets every outstanding result come back.
    task automatic wait_for_drain();
        @(negedge clk);
        upd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [kdqd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [kdqd_pkg::PERIOD_W-1:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [kdqd_pkg::AB_W-1:0] turn_knob(
        input logic [kdqd_pkg::AB_W-1:0] ab);
        logic [1:0] g;
        int unsigned roll;
        roll = $urandom_range(99);
        g = {ab[1], ab[1] ^ ab[0]};
        if (roll < 55)
            return ab;
        if (roll >= 95)
            return kdqd_pkg::AB_W'($urandom_range(3));
        if (roll < 75)
            g = g + 2'd1;
        else
            g = g - 2'd1;
        return {g[1], g[1] ^ g[0]};
    endfunction

    // Key presses that bounce for a few updates and then hold, mixed with
    // stretches of pure noise; time mostly advances on the scale of the periods.
    task automatic run_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned span;
        int unsigned bounce;
        int unsigned roll;
        int unsigned time_scale;
        logic [KEY_W-1:0] target;
        logic [KEY_W-1:0] keys;
        logic noisy;
        sent = 0;
        while (sent < count)
        begin
            target = KEY_W'($urandom_range(63));
            bounce = $urandom_range(0, 3);
            span = $urandom_range(3, 25);
            noisy = ($urandom_range(99) < 15);
            for (int i = 0; i < span && sent < count; i++)
            begin
                time_scale = (int'(debounce_len) >> 2) + int'(scan_ms) + 1;
                roll = $urandom_range(99);
                if (roll < 3)
                    stim_ms = $urandom;
                else if (roll < 6)
                    stim_ms = stim_ms - $urandom_range(1, 50);
                else
                    stim_ms = stim_ms + $urandom_range(0, time_scale);
                keys = (noisy || i < bounce) ? KEY_W'($urandom_range(63)) : target;
                enc0_pins = turn_knob(enc0_pins);
                enc1_pins = turn_knob(enc1_pins);
                send_update(stim_ms, keys, enc0_pins, enc1_pins);
                sent++;
            end
        end
    endtask

    task automatic test_reset_defaults();
        // The first update only seeds the encoder pins.
        send_update(32'd0, 6'h00, 2'b11, 2'b10);
        send_update(32'd5, 6'h3F, 2'b10, 2'b11);
        send_update(32'd10, 6'h3F, 2'b00, 2'b01);
        send_update(32'd25, 6'h3F, 2'b01, 2'b00);
        // Too soon after the last sample, so the keys are not looked at.
        send_update(32'd26, 6'h00, 2'b11, 2'b10);
        // Both pins change at once on each encoder.
        send_update(32'd30, 6'h00, 2'b00, 2'b01);
        send_update(32'd40, 6'h2A, 2'b00, 2'b01);
        send_update(32'd50, 6'h2A, 2'b10, 2'b11);
        // Keys 1, 3 and 5 settle at the state they already held: no edge flag.
        send_update(32'd60, 6'h2A, 2'b11, 2'b10);
        send_update(32'd70, 6'h2A, 2'b01, 2'b00);
        send_update(32'd71, 6'h2A, 2'b00, 2'b01);
        send_update(32'hFFFF_FFF0, 6'h15, 2'b01, 2'b11);
        send_update(32'hFFFF_FFFF, 6'h15, 2'b11, 2'b10);
        send_update(32'h0000_0003, 6'h15, 2'b10, 2'b00);
        send_update(32'h0000_0004, 6'h15, 2'b00, 2'b01);
        send_update(32'h8000_0000, 6'h00, 2'b00, 2'b01);
        send_update(32'h8000_0014, 6'h00, 2'b11, 2'b00);
        send_update(32'h8000_0020, 6'h3F, 2'b10, 2'b10);
    endtask

    task automatic test_register_extremes();
        write_register(kdqd_pkg::REG_DEBOUNCE_PERIOD, '0);
        write_register(kdqd_pkg::REG_SCAN_PERIOD, '0);
        // Every update samples, and a change is confirmed on the sample that saw it.
        send_update(32'd100, 6'h3F, 2'b00, 2'b00);
        send_update(32'd100, 6'h00, 2'b01, 2'b10);
        send_update(32'd100, 6'h15, 2'b11, 2'b11);
        send_update(32'd101, 6'h2A, 2'b10, 2'b01);
        write_register(kdqd_pkg::REG_DEBOUNCE_PERIOD, '1);
        write_register(kdqd_pkg::REG_SCAN_PERIOD, '1);
        send_update(32'd65635, 6'h00, 2'b00, 2'b00);
        send_update(32'd65636, 6'h00, 2'b01, 2'b10);
        // An index past the register list must leave both periods alone.
        write_register(REG_BEYOND_LIST, 16'h0000);
        send_update(32'd131170, 6'h00, 2'b11, 2'b11);
        send_update(32'd131171, 6'h00, 2'b10, 2'b01);
        send_update(32'd196706, 6'h3F, 2'b00, 2'b00);
        send_update(32'd262241, 6'h3F, 2'b01, 2'b10);
    endtask

    task automatic test_random_settings();
        logic [kdqd_pkg::PERIOD_W-1:0] debounce_set [6];
        logic [kdqd_pkg::PERIOD_W-1:0] scan_set [6];
        debounce_set = '{16'd20, 16'd0, 16'hFFFF, 16'd3, 16'd0, 16'd1};
        scan_set = '{16'd5, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0};
        debounce_set[4] = kdqd_pkg::PERIOD_W'($urandom_range(1, 40));
        scan_set[4] = kdqd_pkg::PERIOD_W'($urandom_range(0, 10));
        for (int s = 0; s < 6; s++)
        begin
            write_register(kdqd_pkg::REG_DEBOUNCE_PERIOD, debounce_set[s]);
            write_register(kdqd_pkg::REG_SCAN_PERIOD, scan_set[s]);
            gaps_enabled = (s != 3);
            run_random_traffic(SEGMENT_ITEMS);
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_result_backpressure();
        write_register(kdqd_pkg::REG_DEBOUNCE_PERIOD, kdqd_pkg::DEBOUNCE_RESET);
        write_register(kdqd_pkg::REG_SCAN_PERIOD, kdqd_pkg::SCAN_RESET);
        gaps_enabled = 1'b0;
        @(posedge clk);
        hold_off_left = HOLD_OFF_CYCLES;
        run_random_traffic(40);
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        upd_if.valid = 1'b0;
        upd_if.now_ms = '0;
        upd_if.key_raw = '0;
        upd_if.enc0_ab = '0;
        upd_if.enc1_ab = '0;
        res_if.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        test_result_backpressure();

        wait_for_drain();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
